// File: rtl/dbs_pkg.sv
// Shared types and constants for the depth bucket sorter.
// Used by every module in rtl/ except dbs_ram; depends on nothing.
`timescale 1ns / 1ps

package dbs_pkg;

  localparam int unsigned MaxPoints = 4096;
  localparam int unsigned Bins      = 128;
  localparam int unsigned IdxW      = 12;
  localparam int unsigned CntW      = 13;
  localparam int unsigned BinW      = 7;
  localparam int unsigned DepthW    = 32;
  localparam int unsigned NumW      = 41;

  localparam logic [DepthW-1:0] DepthMostPos = {1'b0, {(DepthW-1){1'b1}}};
  localparam logic [DepthW-1:0] DepthMostNeg = {1'b1, {(DepthW-1){1'b0}}};

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNSORTED = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] depth_value;
    logic               is_last;
    logic [11:0]        position;
  } in_item_t;

  typedef struct packed {
    logic [11:0] point_index;
    logic [6:0]  bucket;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } cmd_t;

endpackage

// File: rtl/depth_bucket_sort.sv
// Top level of the depth bucket sorter: front queue plus sort/lookup engine.
// Depends on dbs_pkg, dbs_front, dbs_back (and dbs_ram through dbs_back).
`timescale 1ns / 1ps
//
//   channel | valid       | stall        | payload
//   --------+-------------+--------------+------------------------------
//   input   | in_valid_i  | in_stall_o   | in_item_i  (dbs_pkg::in_item_t)
//   output  | out_valid_o | out_stall_i  | out_item_o (dbs_pkg::out_item_t)
//
// A push is taken in the idle state. A push marked last starts the sort: clear
// the histogram, then per point bin and count (read, divider load, eight
// restoring divider steps, bucket write, count update), a prefix sum over the
// bins and a scatter per point; items queue in front meanwhile. A read is
// answered by status when unsorted or out of range, else through the order
// and bucket memories. Reset clears the queue, the count and the sorted flag;
// memories need no clearing. A stalled output holds the engine on its next read.

module depth_bucket_sort (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dbs_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dbs_pkg::out_item_t out_item_o
);

  dbs_pkg::cmd_t cmd;
  logic          cmd_pop;

  // accept and queue items
  dbs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  // load, sort and answer reads
  dbs_back u_back (
    .clk_i, .rst_ni, .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .out_valid_o, .out_stall_i, .out_item_o
  );

endmodule

// File: rtl/dbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package use.
`timescale 1ns / 1ps

module dbs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/dbs_front.sv
// Front end: accepts items and holds them in a two-entry queue.
// Depends on dbs_pkg.
`timescale 1ns / 1ps

module dbs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dbs_pkg::in_item_t in_item_i,
  output dbs_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);

  dbs_pkg::in_item_t slot_q [2];
  dbs_pkg::in_item_t slot_d [2];
  logic [1:0] fill_q, fill_d;
  logic       push;

  assign in_stall_o = (fill_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign cmd_o.valid = (fill_q != 2'd0);
  assign cmd_o.item  = slot_q[0];

  always_comb begin
    slot_d = slot_q;
    fill_d = fill_q;
    if (cmd_pop_i && fill_q != 2'd0) begin
      slot_d[0] = slot_q[1];
      fill_d    = fill_q - 2'd1;
    end
    if (push) begin
      // place behind whatever stays in the queue
      slot_d[fill_d[0]] = in_item_i;
      fill_d            = fill_d + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

// File: rtl/dbs_back.sv
// Back end: loads depths, runs the bin/count/prefix/scatter passes, answers reads.
// Depends on dbs_pkg and dbs_ram.
`timescale 1ns / 1ps

module dbs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dbs_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dbs_pkg::out_item_t out_item_o
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_CLR    = 13'b0000000000010,
    S_BIN_RD = 13'b0000000000100,
    S_BIN_LD = 13'b0000000001000,
    S_DIV    = 13'b0000000010000,
    S_BWR    = 13'b0000000100000,
    S_CNT    = 13'b0000001000000,
    S_PRE_RD = 13'b0000010000000,
    S_PRE_WR = 13'b0000100000000,
    S_SC_RD  = 13'b0001000000000,
    S_SC_B   = 13'b0010000000000,
    S_SC_WR  = 13'b0100000000000,
    S_RD_O   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   rd_wait_q, rd_wait_d;   // bucket read of a sorted position in flight
  logic   rd_emit_q, rd_emit_d;

  logic [dbs_pkg::CntW-1:0]   count_q, count_d, k_q, k_d, sum_q, sum_d;
  logic [dbs_pkg::DepthW-1:0] min_q, min_d, max_q, max_d, range_q, range_d;
  logic                       sorted_q, sorted_d;
  logic [dbs_pkg::BinW:0]     b_q, b_d;
  logic [dbs_pkg::BinW-1:0]   bk_q, bk_d;
  logic [dbs_pkg::NumW-1:0]   rem_q, rem_d;
  logic [2:0]                 i_q, i_d;
  logic [7:0]                 quo_q, quo_d;
  logic [dbs_pkg::IdxW-1:0]   idx_q, idx_d;
  logic                       out_valid_q, out_valid_d;
  dbs_pkg::out_item_t         out_q, out_d;

  // memory ports
  logic                       dep_we, bkt_we, ord_we, cnt_we;
  logic [dbs_pkg::IdxW-1:0]   dep_waddr, dep_raddr, bkt_waddr, bkt_raddr;
  logic [dbs_pkg::IdxW-1:0]   ord_waddr, ord_raddr, ord_wdata, ord_rdata;
  logic [dbs_pkg::BinW-1:0]   cnt_waddr, cnt_raddr, bkt_wdata, bkt_rdata;
  logic [dbs_pkg::CntW-1:0]   cnt_wdata, cnt_rdata;
  logic [dbs_pkg::DepthW-1:0] dep_rdata;

  logic                       out_free;
  logic [dbs_pkg::CntW-1:0]   base_count;
  logic [dbs_pkg::DepthW-1:0] base_min, base_max, diff;
  logic [dbs_pkg::NumW-1:0]   den_sh;
  logic [dbs_pkg::NumW:0]     trial;
  logic [7:0]                 quo_next;
  dbs_pkg::in_item_t          it;

  assign it       = cmd_i.item;
  assign out_free = !out_valid_q || !out_stall_i;
  assign base_count = sorted_q ? '0 : count_q;
  assign base_min   = sorted_q ? dbs_pkg::DepthMostPos : min_q;
  assign base_max   = sorted_q ? dbs_pkg::DepthMostNeg : max_q;
  assign diff       = dep_rdata - min_q;
  assign den_sh     = {{(dbs_pkg::NumW-dbs_pkg::DepthW-1){1'b0}}, range_q, 1'b0} << i_q;
  assign trial      = {1'b0, rem_q} - {1'b0, den_sh};
  assign quo_next   = trial[dbs_pkg::NumW] ? quo_q : (quo_q | (8'd1 << i_q));

  always_comb begin
    state_d     = state_q;
    rd_wait_d   = rd_wait_q;
    rd_emit_d   = rd_emit_q;
    count_d     = count_q;
    k_d         = k_q;
    sum_d       = sum_q;
    min_d       = min_q;
    max_d       = max_q;
    range_d     = range_q;
    sorted_d    = sorted_q;
    b_d         = b_q;
    bk_d        = bk_q;
    rem_d       = rem_q;
    i_d         = i_q;
    quo_d       = quo_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    dep_we = 1'b0; bkt_we = 1'b0; ord_we = 1'b0; cnt_we = 1'b0;
    dep_waddr = base_count[dbs_pkg::IdxW-1:0];
    dep_raddr = k_q[dbs_pkg::IdxW-1:0];
    bkt_waddr = k_q[dbs_pkg::IdxW-1:0];
    bkt_wdata = quo_q[dbs_pkg::BinW-1:0];
    bkt_raddr = idx_q;
    ord_waddr = cnt_rdata[dbs_pkg::IdxW-1:0];
    ord_wdata = k_q[dbs_pkg::IdxW-1:0];
    ord_raddr = it.position;
    cnt_waddr = b_q[dbs_pkg::BinW-1:0];
    cnt_wdata = '0;
    cnt_raddr = b_q[dbs_pkg::BinW-1:0];

    case (state_q)
      S_IDLE: begin
        if (rd_emit_q) begin
          // bucket of the sorted position is on the read port; emit once free
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d = '{point_index: idx_q, bucket: bkt_rdata, status: dbs_pkg::ST_OK};
            rd_emit_d = 1'b0;
          end
        end else if (rd_wait_q) begin
          rd_wait_d = 1'b0;
          rd_emit_d = 1'b1;
        end else if (cmd_i.valid && it.req_type == dbs_pkg::REQ_PUSH) begin
          cmd_pop_o = 1'b1;
          count_d   = base_count;
          min_d     = base_min;
          max_d     = base_max;
          sorted_d  = 1'b0;
          if (base_count < dbs_pkg::CntW'(dbs_pkg::MaxPoints)) begin
            dep_we  = 1'b1;
            count_d = base_count + 1'b1;
            if ($signed(it.depth_value) < $signed(base_min)) min_d = it.depth_value;
            if ($signed(it.depth_value) > $signed(base_max)) max_d = it.depth_value;
          end
          if (it.is_last) begin
            b_d     = '0;
            state_d = S_CLR;
          end
        end else if (cmd_i.valid) begin
          if (!sorted_q || {1'b0, it.position} >= count_q) begin
            if (out_free) begin
              cmd_pop_o   = 1'b1;
              out_valid_d = 1'b1;
              out_d = '{point_index: '0, bucket: '0,
                        status: sorted_q ? dbs_pkg::ST_RANGE : dbs_pkg::ST_UNSORTED};
            end
          end else begin
            cmd_pop_o = 1'b1;
            state_d   = S_RD_O;
          end
        end
      end
      S_RD_O: begin
        idx_d     = ord_rdata;
        rd_wait_d = 1'b1;
        state_d   = S_IDLE;
      end
      S_CLR: begin
        cnt_we = 1'b1;
        b_d    = b_q + 1'b1;
        if (b_q == (dbs_pkg::BinW+1)'(dbs_pkg::Bins - 1)) begin
          range_d = (count_q != '0 && $signed(max_q) > $signed(min_q)) ?
                    (max_q - min_q) : dbs_pkg::DepthW'(1);
          k_d     = '0;
          b_d     = '0;
          sum_d   = '0;
          state_d = (count_q == '0) ? S_PRE_RD : S_BIN_RD;
        end
      end
      S_BIN_RD: state_d = S_BIN_LD;
      S_BIN_LD: begin
        rem_d   = dbs_pkg::NumW'(diff) * dbs_pkg::NumW'(254) + dbs_pkg::NumW'(range_q);
        i_d     = 3'd7;
        quo_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        // one restoring quotient bit per cycle
        if (!trial[dbs_pkg::NumW]) rem_d = trial[dbs_pkg::NumW-1:0];
        quo_d = quo_next;
        i_d   = i_q - 3'd1;
        if (i_q == 3'd0) state_d = S_BWR;
      end
      S_BWR: begin
        bk_d      = quo_q[7] ? dbs_pkg::BinW'(dbs_pkg::Bins - 1) : quo_q[dbs_pkg::BinW-1:0];
        bkt_we    = 1'b1;
        bkt_wdata = bk_d;
        cnt_raddr = bk_d;
        state_d   = S_CNT;
      end
      S_CNT: begin
        cnt_we    = 1'b1;
        cnt_waddr = bk_q;
        cnt_wdata = cnt_rdata + 1'b1;
        k_d       = k_q + 1'b1;
        state_d   = (k_d == count_q) ? S_PRE_RD : S_BIN_RD;
      end
      S_PRE_RD: state_d = S_PRE_WR;
      S_PRE_WR: begin
        cnt_we    = 1'b1;
        cnt_wdata = sum_q;
        sum_d     = sum_q + cnt_rdata;
        b_d       = b_q + 1'b1;
        state_d   = S_PRE_RD;
        if (b_q == (dbs_pkg::BinW+1)'(dbs_pkg::Bins - 1)) begin
          k_d = '0;
          if (count_q == '0) begin
            sorted_d = 1'b1;
            state_d  = S_IDLE;
          end else begin
            state_d = S_SC_RD;
          end
        end
      end
      S_SC_RD: begin
        bkt_raddr = k_q[dbs_pkg::IdxW-1:0];
        state_d   = S_SC_B;
      end
      S_SC_B: begin
        bk_d      = bkt_rdata;
        cnt_raddr = bkt_rdata;
        state_d   = S_SC_WR;
      end
      S_SC_WR: begin
        ord_we    = 1'b1;
        cnt_we    = 1'b1;
        cnt_waddr = bk_q;
        cnt_wdata = cnt_rdata + 1'b1;
        k_d       = k_q + 1'b1;
        if (k_d == count_q) begin
          sorted_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_SC_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_wait_q   <= 1'b0;
      rd_emit_q   <= 1'b0;
      count_q     <= '0;
      min_q       <= dbs_pkg::DepthMostPos;
      max_q       <= dbs_pkg::DepthMostNeg;
      sorted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_wait_q   <= rd_wait_d;
      rd_emit_q   <= rd_emit_d;
      count_q     <= count_d;
      min_q       <= min_d;
      max_q       <= max_d;
      sorted_q    <= sorted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    sum_q   <= sum_d;
    range_q <= range_d;
    b_q     <= b_d;
    bk_q    <= bk_d;
    rem_q   <= rem_d;
    i_q     <= i_d;
    quo_q   <= quo_d;
    idx_q   <= idx_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  dbs_ram #(.Width(dbs_pkg::DepthW), .Depth(dbs_pkg::MaxPoints)) u_depth_ram (
    .clk_i, .we_i(dep_we), .waddr_i(dep_waddr), .wdata_i(it.depth_value),
    .raddr_i(dep_raddr), .rdata_o(dep_rdata)
  );

  dbs_ram #(.Width(dbs_pkg::BinW), .Depth(dbs_pkg::MaxPoints)) u_bucket_ram (
    .clk_i, .we_i(bkt_we), .waddr_i(bkt_waddr), .wdata_i(bkt_wdata),
    .raddr_i(bkt_raddr), .rdata_o(bkt_rdata)
  );

  dbs_ram #(.Width(dbs_pkg::IdxW), .Depth(dbs_pkg::MaxPoints)) u_order_ram (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(ord_wdata),
    .raddr_i(ord_raddr), .rdata_o(ord_rdata)
  );

  dbs_ram #(.Width(dbs_pkg::CntW), .Depth(dbs_pkg::Bins)) u_count_ram (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(cnt_raddr), .rdata_o(cnt_rdata)
  );

endmodule
